[rtl/utd_pkg.sv]
// Shared types, constants and helper functions of the USB descriptor chain builder.
package utd_pkg;

   // Largest number of descriptors one transfer may produce.
   localparam int MAX_DESCRIPTORS = 64;
   localparam int RESULT_CAP      = 64;
   localparam int LIMIT           = (MAX_DESCRIPTORS > RESULT_CAP) ? RESULT_CAP
                                                                   : MAX_DESCRIPTORS;
   localparam int LIMIT_W         = $clog2(LIMIT + 1);

   // Field widths.
   localparam int LEN_W  = 16;
   localparam int MPS_W  = 10;
   localparam int ADDR_W = 32;
   localparam int WORD_W = 32;
   localparam int CODE_W = 11;

   // Width of the byte capacity product and of its compare against the length.
   localparam int PROD_W = MPS_W + LIMIT_W;
   localparam int CMP_W  = (PROD_W > LEN_W) ? PROD_W : LEN_W;

   // Direction codes and token PIDs.
   localparam logic [1:0] DIR_SETUP = 2'd0;
   localparam logic [1:0] DIR_IN    = 2'd1;
   localparam logic [7:0] PID_SETUP = 8'h2D;
   localparam logic [7:0] PID_IN    = 8'h69;
   localparam logic [7:0] PID_OUT   = 8'hE1;

   // Control word bits.
   localparam int CTL_ACTIVE_BIT = 23;
   localparam int CTL_IOC_BIT    = 24;
   localparam int CTL_LS_BIT     = 26;
   localparam int CTL_CERR_LO    = 27;
   localparam logic [1:0] CTL_CERR_VAL = 2'd3;

   // Length code of a zero-length packet.
   localparam logic [CODE_W-1:0] ZERO_LEN_CODE = 11'h7FF;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CHECK,
      ST_EMIT
   } state_type;

   // Result of one pass through the packet step unit.
   typedef struct packed {
      logic [CODE_W-1:0] code;
      logic [LEN_W-1:0]  remain;
      logic [ADDR_W-1:0] addr_next;
      logic              last;
   } step_type;

   // Token PID of a direction code; the unused code is treated as out.
   function automatic logic [7:0] pid_of(input logic [1:0] dir);
      logic [7:0] pid;
      unique case (dir)
         DIR_SETUP: pid = PID_SETUP;
         DIR_IN:    pid = PID_IN;
         default:   pid = PID_OUT;
      endcase
      return pid;
   endfunction

endpackage

[rtl/utd_step_unit.sv]
// Packet step unit: cuts one packet off the remaining transfer.
module utd_step_unit (
   input  logic [utd_pkg::LEN_W-1:0]  bytes_left,
   input  logic [utd_pkg::MPS_W-1:0]  max_packet_size,
   input  logic [utd_pkg::ADDR_W-1:0] current_address,
   output utd_pkg::step_type          step
);
   import utd_pkg::*;

   logic [LEN_W-1:0] mps_ext;
   logic [LEN_W-1:0] chunk;
   logic [LEN_W-1:0] chunk_m1;

   // The packet is the smaller of the remaining bytes and the packet size.
   always_comb begin
      mps_ext  = LEN_W'(max_packet_size);
      chunk    = (bytes_left > mps_ext) ? mps_ext : bytes_left;
      chunk_m1 = chunk - LEN_W'(1);
   end

   // Remaining bytes, next address and the encoded packet length.
   always_comb begin
      step.remain    = bytes_left - chunk;
      step.addr_next = current_address + ADDR_W'(chunk);
      step.last      = (bytes_left <= mps_ext);
      step.code      = (chunk == '0) ? ZERO_LEN_CODE : chunk_m1[CODE_W-1:0];
   end

endmodule

[rtl/usb_td_chain_builder.sv]
// Top level of the USB transfer descriptor chain builder.
// The block takes one transfer request and emits one descriptor per packet of at
// most max_packet_size bytes, with the data toggle alternating from start_toggle and
// the buffer address advancing by each packet's length; a zero-length transfer gives
// one zero-length descriptor, and a transfer needing more than min(MAX_DESCRIPTORS, 64)
// packets gives a single result with too_many set. After a request is accepted, the
// check state tests the packet count (packet size times the limit against the length),
// then one descriptor is produced per cycle while the output register is free, by a
// shared subtract/add step unit; req_ready is high only between requests. Results
// sit in an output register, so a new request can be taken while the last result waits.
module usb_td_chain_builder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_direction,
   input  logic [6:0]  req_device_address,
   input  logic [3:0]  req_endpoint_number,
   input  logic        req_start_toggle,
   input  logic        req_low_speed,
   input  logic [15:0] req_transfer_length,
   input  logic [9:0]  req_max_packet_size,
   input  logic [31:0] req_buffer_address,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_control_word,
   output logic [31:0] rsp_token_word,
   output logic [31:0] rsp_data_address,
   output logic        rsp_last_descriptor,
   output logic        rsp_too_many,
   output logic        rsp_next_toggle
);
   import utd_pkg::*;

   state_type state_ff, state_in;

   // Held request fields.
   logic [1:0]        dir_ff;
   logic [6:0]        dev_ff;
   logic [3:0]        ep_ff;
   logic              ls_ff;
   logic [MPS_W-1:0]  mps_ff;
   logic              start_tog_ff;

   // Working state of the transfer.
   logic [LEN_W-1:0]  bytes_left_ff, bytes_left_in;
   logic [ADDR_W-1:0] cur_addr_ff, cur_addr_in;
   logic              toggle_ff, toggle_in;

   // Output register.
   logic              rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0] ctl_ff, ctl_in;
   logic [WORD_W-1:0] tok_ff, tok_in;
   logic [ADDR_W-1:0] daddr_ff, daddr_in;
   logic              last_ff, last_in;
   logic              many_ff, many_in;
   logic              ntog_ff, ntog_in;

   logic              accept;
   logic              out_free;
   logic [PROD_W-1:0] limit_bytes;
   logic              too_many;
   logic [WORD_W-1:0] ctl_base;
   step_type          step;

   assign accept   = req_valid && req_ready;
   assign out_free = !rsp_valid_ff || rsp_ready;

   // Shared packet step unit.
   utd_step_unit u_step (
      .bytes_left      (bytes_left_ff),
      .max_packet_size (mps_ff),
      .current_address (cur_addr_ff),
      .step            (step)
   );

   // Packet count check: more packets than the limit means the length exceeds
   // limit times the packet size.
   always_comb begin
      limit_bytes = PROD_W'(mps_ff) * PROD_W'(LIMIT);
      too_many    = CMP_W'(bytes_left_ff) > CMP_W'(limit_bytes);
   end

   // Control word bits common to every descriptor of the request.
   always_comb begin
      ctl_base                                = '0;
      ctl_base[CTL_ACTIVE_BIT]                = 1'b1;
      ctl_base[CTL_LS_BIT]                    = ls_ff;
      ctl_base[CTL_CERR_LO+1:CTL_CERR_LO]     = CTL_CERR_VAL;
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (too_many) begin
               if (out_free) state_in = ST_IDLE;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free && step.last) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs of the sequencer: working state and result register loads.
   always_comb begin
      bytes_left_in = bytes_left_ff;
      cur_addr_in   = cur_addr_ff;
      toggle_in     = toggle_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      ctl_in        = ctl_ff;
      tok_in        = tok_ff;
      daddr_in      = daddr_ff;
      last_in       = last_ff;
      many_in       = many_ff;
      ntog_in       = ntog_ff;
      req_ready     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (accept) begin
               bytes_left_in = req_transfer_length;
               cur_addr_in   = req_buffer_address;
               toggle_in     = req_start_toggle;
            end
         end
         ST_CHECK: begin
            if (too_many && out_free) begin
               rsp_valid_in = 1'b1;
               ctl_in       = '0;
               tok_in       = '0;
               daddr_in     = '0;
               last_in      = 1'b1;
               many_in      = 1'b1;
               ntog_in      = start_tog_ff;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in             = 1'b1;
               ctl_in                   = ctl_base;
               ctl_in[CTL_IOC_BIT]      = step.last;
               tok_in                   = {step.code, 1'b0, toggle_ff, ep_ff, dev_ff,
                                           pid_of(dir_ff)};
               daddr_in                 = cur_addr_ff;
               last_in                  = step.last;
               many_in                  = 1'b0;
               ntog_in                  = step.last && !toggle_ff;
               bytes_left_in            = step.remain;
               cur_addr_in              = step.addr_next;
               toggle_in                = !toggle_ff;
            end
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (accept) begin
         dir_ff       <= req_direction;
         dev_ff       <= req_device_address;
         ep_ff        <= req_endpoint_number;
         ls_ff        <= req_low_speed;
         mps_ff       <= req_max_packet_size;
         start_tog_ff <= req_start_toggle;
      end
      bytes_left_ff <= bytes_left_in;
      cur_addr_ff   <= cur_addr_in;
      toggle_ff     <= toggle_in;
      ctl_ff        <= ctl_in;
      tok_ff        <= tok_in;
      daddr_ff      <= daddr_in;
      last_ff       <= last_in;
      many_ff       <= many_in;
      ntog_ff       <= ntog_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_control_word    = ctl_ff;
   assign rsp_token_word      = tok_ff;
   assign rsp_data_address    = daddr_ff;
   assign rsp_last_descriptor = last_ff;
   assign rsp_too_many        = many_ff;
   assign rsp_next_toggle     = ntog_ff;

   // An error result always closes its request.
   a_error_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_too_many |-> rsp_last_descriptor)
      else $error("error result without last_descriptor");

   // The next toggle is reported only on the final result.
   a_ntog_only_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_descriptor |-> !rsp_next_toggle)
      else $error("next_toggle set on a non-final result");

   // An accepted request is always checked before any descriptor is built.
   a_accept_to_check: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == ST_CHECK)
      else $error("accepted request did not enter the check step");

   // The remaining byte count never grows while descriptors are built.
   a_bytes_shrink: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EMIT && $past(state_ff) == ST_EMIT
      |-> bytes_left_ff <= $past(bytes_left_ff))
      else $error("remaining byte count increased");

endmodule

[verif/td_chain_checker.sv]
// Checker that predicts and compares the descriptors of the USB transfer descriptor chain builder.
`timescale 1ns / 100ps
module td_chain_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [1:0]  req_direction,
   input  logic [6:0]  req_device_address,
   input  logic [3:0]  req_endpoint_number,
   input  logic        req_start_toggle,
   input  logic        req_low_speed,
   input  logic [15:0] req_transfer_length,
   input  logic [9:0]  req_max_packet_size,
   input  logic [31:0] req_buffer_address,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [31:0] rsp_control_word,
   input  logic [31:0] rsp_token_word,
   input  logic [31:0] rsp_data_address,
   input  logic        rsp_last_descriptor,
   input  logic        rsp_too_many,
   input  logic        rsp_next_toggle,
   output int          failures,
   output int          pending
);
   import utd_pkg::*;

   // One descriptor as it should leave the block.
   typedef struct packed {
      logic [31:0] control_word;
      logic [31:0] token_word;
      logic [31:0] data_address;
      logic        last_descriptor;
      logic        too_many;
      logic        next_toggle;
   } descriptor_type;

   descriptor_type expected_descriptors[$];
   int             result_count = 0;

   initial begin
      failures = 0;
      pending  = 0;
   end

   // Print one line for a mismatch and count it.
   task automatic report_mismatch(input string message);
      failures++;
      $display("descriptor %0d: %s", result_count, message);
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         report_mismatch($sformatf("%s expected 0x%08h, got 0x%08h", name, want, got));
      end
   endtask

   // Cut one transfer into packets and queue the descriptors it must produce.
   task automatic build_descriptor_chain(
      input logic [1:0]  direction,
      input logic [6:0]  device,
      input logic [3:0]  endpoint,
      input logic        toggle,
      input logic        slow,
      input logic [15:0] length,
      input logic [9:0]  packet_size,
      input logic [31:0] buffer
   );
      descriptor_type desc;
      logic [7:0]     pid;
      logic [31:0]    base_ctl;
      logic [31:0]    addr;
      logic [10:0]    code;
      logic           tog;
      int             packets;
      int             left;
      int             chunk;
      int             k;

      case (direction)
         DIR_SETUP: pid = PID_SETUP;
         DIR_IN:    pid = PID_IN;
         default:   pid = PID_OUT;
      endcase

      // A nonzero length with no packet size can never finish.
      if (length == 0) begin
         packets = 1;
      end else if (packet_size == 0) begin
         packets = LIMIT + 1;
      end else begin
         packets = (int'(length) + int'(packet_size) - 1) / int'(packet_size);
      end

      if (packets > LIMIT) begin
         desc = '0;
         desc.last_descriptor = 1'b1;
         desc.too_many        = 1'b1;
         desc.next_toggle     = toggle;
         expected_descriptors.push_back(desc);
      end else begin
         base_ctl = '0;
         base_ctl[CTL_ACTIVE_BIT]    = 1'b1;
         base_ctl[CTL_CERR_LO +: 2]  = CTL_CERR_VAL;
         base_ctl[CTL_LS_BIT]        = slow;
         left = int'(length);
         addr = buffer;
         tog  = toggle;
         for (k = 0; k < packets; k++) begin
            chunk = (left > int'(packet_size)) ? int'(packet_size) : left;
            code  = (chunk == 0) ? ZERO_LEN_CODE : 11'(chunk - 1);
            desc = '0;
            desc.last_descriptor          = (k == packets - 1);
            desc.control_word             = base_ctl;
            desc.control_word[CTL_IOC_BIT] = desc.last_descriptor;
            desc.token_word               = {code, 1'b0, tog, endpoint, device, pid};
            desc.data_address             = addr;
            desc.next_toggle              = desc.last_descriptor ? ~tog : 1'b0;
            expected_descriptors.push_back(desc);
            addr = addr + 32'(chunk);
            left = left - chunk;
            tog  = ~tog;
         end
      end
   endtask

   // Compare each accepted descriptor, then predict from each accepted request.
   always @(posedge clock) begin
      descriptor_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_descriptors.size() == 0) begin
               report_mismatch("descriptor arrived with none expected");
            end else begin
               want = expected_descriptors.pop_front();
               check_field("control_word", want.control_word, rsp_control_word);
               check_field("token_word", want.token_word, rsp_token_word);
               check_field("data_address", want.data_address, rsp_data_address);
               check_field("last_descriptor", 32'(want.last_descriptor),
                           32'(rsp_last_descriptor));
               check_field("too_many", 32'(want.too_many), 32'(rsp_too_many));
               check_field("next_toggle", 32'(want.next_toggle), 32'(rsp_next_toggle));
            end
            result_count++;
         end
         if (req_valid && req_ready) begin
            build_descriptor_chain(req_direction, req_device_address, req_endpoint_number,
                                   req_start_toggle, req_low_speed, req_transfer_length,
                                   req_max_packet_size, req_buffer_address);
         end
         pending = expected_descriptors.size();
      end
   end

endmodule

[verif/usb_td_chain_builder_tb.sv]
// Testbench top that drives transfer requests into the USB descriptor chain builder.
`timescale 1ns / 100ps
module usb_td_chain_builder_tb;
   import utd_pkg::*;

   // Direction codes the package leaves unnamed.
   localparam logic [1:0] DIR_OUT   = 2'd2;
   localparam logic [1:0] DIR_SPARE = 2'd3;

   localparam int RANDOM_REQUESTS = 200;
   localparam int CYCLE_LIMIT     = 2_000_000;
   localparam int DRAIN_CYCLES    = 150;

   typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [1:0]  req_direction;
   logic [6:0]  req_device_address;
   logic [3:0]  req_endpoint_number;
   logic        req_start_toggle;
   logic        req_low_speed;
   logic [15:0] req_transfer_length;
   logic [9:0]  req_max_packet_size;
   logic [31:0] req_buffer_address;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [31:0] rsp_control_word;
   logic [31:0] rsp_token_word;
   logic [31:0] rsp_data_address;
   logic        rsp_last_descriptor;
   logic        rsp_too_many;
   logic        rsp_next_toggle;

   int            failures;
   int            pending;
   int            cycle_count = 0;
   idle_mode_type idle_mode   = IDLE_NONE;

   usb_td_chain_builder dut (.*);

   td_chain_checker chain_check (.*);

   // Clock with a 4 ns period.
   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   // Guard against a hang.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   function automatic bit sender_pauses();
      case (idle_mode)
         IDLE_SENDER: return $urandom_range(0, 99) < 87;
         IDLE_BOTH:   return $urandom_range(0, 99) < 17;
         default:     return 1'b0;
      endcase
   endfunction

   function automatic bit receiver_stalls();
      case (idle_mode)
         IDLE_RECEIVER: return $urandom_range(0, 99) < 87;
         IDLE_BOTH:     return $urandom_range(0, 99) < 17;
         default:       return 1'b0;
      endcase
   endfunction

   // The result side takes descriptors or stalls according to the current mode.
   always @(negedge clock) begin
      rsp_ready <= !receiver_stalls();
   end

   // Present one request, after an optional gap, and hold it until accepted.
   task automatic send_request(
      input logic [1:0]  direction,
      input logic [6:0]  device,
      input logic [3:0]  endpoint,
      input logic        toggle,
      input logic        slow,
      input logic [15:0] length,
      input logic [9:0]  packet_size,
      input logic [31:0] buffer
   );
      @(negedge clock);
      while (sender_pauses()) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid           <= 1'b1;
      req_direction       <= direction;
      req_device_address  <= device;
      req_endpoint_number <= endpoint;
      req_start_toggle    <= toggle;
      req_low_speed       <= slow;
      req_transfer_length <= length;
      req_max_packet_size <= packet_size;
      req_buffer_address  <= buffer;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // Mostly well-formed transfers with short chains, some long chains, some
   // zero-length transfers, some that exceed the descriptor limit, and noise.
   task automatic send_random_request();
      int shape;
      int packet_size;
      int length;
      int packets;
      shape       = $urandom_range(0, 99);
      packet_size = ($urandom_range(0, 1) == 1) ? $urandom_range(1, 64)
                                                : $urandom_range(1, 1023);
      if (shape < 70) begin
         packets = $urandom_range(1, 8);
         length  = (packets - 1) * packet_size + $urandom_range(1, packet_size);
      end else if (shape < 80) begin
         packets = $urandom_range(9, LIMIT);
         length  = (packets - 1) * packet_size + $urandom_range(1, packet_size);
      end else if (shape < 85) begin
         length      = 0;
         packet_size = $urandom_range(0, 1023);
      end else if (shape < 95) begin
         packet_size = $urandom_range(0, 1023);
         length      = (packet_size == 0) ? $urandom_range(1, 65535)
                                          : $urandom_range(LIMIT * packet_size + 1, 65535);
      end else begin
         length      = $urandom_range(0, 65535);
         packet_size = $urandom_range(0, 1023);
      end
      send_request(2'($urandom_range(0, 3)), 7'($urandom_range(0, 127)),
                   4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)), 16'(length), 10'(packet_size),
                   32'($urandom));
   endtask

   initial begin
      reset               = 1'b1;
      req_valid           = 1'b0;
      req_direction       = DIR_SETUP;
      req_device_address  = '0;
      req_endpoint_number = '0;
      req_start_toggle    = 1'b0;
      req_low_speed       = 1'b0;
      req_transfer_length = '0;
      req_max_packet_size = '0;
      req_buffer_address  = '0;
      rsp_ready           = 1'b0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed requests: every direction, field extremes, the descriptor limit,
      // zero lengths and zero packet sizes, and address wrap.
      send_request(DIR_SETUP, 7'd0, 4'd0, 1'b0, 1'b0, 16'd8, 10'd8, 32'h0000_0000);
      send_request(DIR_IN, 7'd1, 4'd1, 1'b0, 1'b0, 16'd0, 10'd64, 32'h1000_0000);
      send_request(DIR_OUT, 7'd2, 4'd2, 1'b1, 1'b0, 16'd100, 10'd64, 32'h2000_0000);
      send_request(DIR_SPARE, 7'd3, 4'd3, 1'b0, 1'b1, 16'd10, 10'd64, 32'h3000_0000);
      send_request(DIR_IN, 7'd4, 4'd4, 1'b1, 1'b0, 16'd0, 10'd0, 32'h4000_0000);
      send_request(DIR_OUT, 7'd5, 4'd5, 1'b1, 1'b1, 16'd5, 10'd0, 32'h5000_0000);
      send_request(DIR_IN, 7'd6, 4'd6, 1'b0, 1'b0, 16'hFFFF, 10'd1, 32'h6000_0000);
      send_request(DIR_OUT, 7'd7, 4'd7, 1'b0, 1'b0, 16'd65472, 10'd1023, 32'h7000_0000);
      send_request(DIR_OUT, 7'd8, 4'd8, 1'b1, 1'b0, 16'd65473, 10'd1023, 32'h8000_0000);
      send_request(DIR_IN, 7'd9, 4'd9, 1'b1, 1'b1, 16'd64, 10'd1, 32'h9000_0000);
      send_request(DIR_IN, 7'd10, 4'd10, 1'b0, 1'b0, 16'd65, 10'd1, 32'hA000_0000);
      send_request(DIR_OUT, 7'd11, 4'd11, 1'b0, 1'b0, 16'd100, 10'd8, 32'hFFFF_FFF0);
      send_request(DIR_SETUP, 7'd127, 4'd15, 1'b1, 1'b1, 16'd1, 10'd1023, 32'hFFFF_FFFF);
      send_request(DIR_SPARE, 7'h2A, 4'h5, 1'b0, 1'b1, 16'hFFFF, 10'd1023, 32'h5555_AAAA);
      send_request(DIR_IN, 7'h55, 4'hA, 1'b1, 1'b0, 16'd1023, 10'd1022, 32'hAAAA_5555);
      send_request(DIR_OUT, 7'h55, 4'hA, 1'b0, 1'b0, 16'd3000, 10'd512, 32'h0000_FF00);
      send_request(DIR_SETUP, 7'd12, 4'd12, 1'b0, 1'b0, 16'd1, 10'd1, 32'h0000_0001);
      send_request(DIR_OUT, 7'd13, 4'd13, 1'b1, 1'b0, 16'd0, 10'd1023, 32'hDEAD_0000);

      // Random requests, one quarter under each idling mode.
      for (int n = 0; n < RANDOM_REQUESTS; n++) begin
         idle_mode = idle_mode_type'((4 * n) / RANDOM_REQUESTS);
         send_random_request();
      end
      @(negedge clock);
      req_valid <= 1'b0;
      idle_mode = IDLE_NONE;

      // Let every expected descriptor arrive, then watch for strays.
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
